>>> rtl/core/ppd_pkg.sv
// Shared constants and register codes for the profile peak detector.
package ppd_pkg;

  // Default sample width and profile length.
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned MAX_ROWS_DEF     = 4096;

  // Fixed widths of the result row and of the spacing register.
  localparam int unsigned ROW_OUT_W = 12;
  localparam int unsigned SPACING_W = 12;

  // Configuration channel widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset value of the minimum peak spacing.
  localparam logic [SPACING_W-1:0] SPACING_RST = 12'd8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_THR    = 2'd0,
    REG_ZERO_THR    = 2'd1,
    REG_MIN_SPACING = 2'd2
  } cfg_reg_e;

endpackage

>>> rtl/core/ppd_if.sv
// Handshake channels of the profile peak detector: samples, results and configuration.
interface ppd_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = ppd_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface ppd_result_if;
  logic                             valid;
  logic                             ready;
  logic [ppd_pkg::ROW_OUT_W-1:0]    baseline_row;
  logic                             flushed_at_end;

  modport source (output valid, baseline_row, flushed_at_end, input ready);
  modport sink   (input valid, baseline_row, flushed_at_end, output ready);
endinterface

interface ppd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppd_pkg::CFG_IDX_W-1:0]   index;
  logic [ppd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ppd_cfg_regs.sv
// Configuration register file: thresholds and minimum peak spacing.
module ppd_cfg_regs #(
  parameter int unsigned SAMPLE_WIDTH = ppd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_valid_i,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]       wr_index_i,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]      wr_data_i,
  output logic                                wr_ready_o,
  output logic signed [SAMPLE_WIDTH-1:0]      peak_thr_o,
  output logic signed [SAMPLE_WIDTH-1:0]      zero_thr_o,
  output logic [ppd_pkg::SPACING_W-1:0]       spacing_o
);
  import ppd_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] peak_thr_q;
  logic signed [SAMPLE_WIDTH-1:0] zero_thr_q;
  logic [SPACING_W-1:0]           spacing_q;

  // Writes always complete in the cycle they are offered.
  assign wr_ready_o = 1'b1;

  // Register decode; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_thr_q <= '0;
      zero_thr_q <= '0;
      spacing_q  <= SPACING_RST;
    end else if (wr_valid_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        REG_PEAK_THR:    peak_thr_q <= $signed(wr_data_i[SAMPLE_WIDTH-1:0]);
        REG_ZERO_THR:    zero_thr_q <= $signed(wr_data_i[SAMPLE_WIDTH-1:0]);
        REG_MIN_SPACING: spacing_q  <= wr_data_i[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  assign peak_thr_o = peak_thr_q;
  assign zero_thr_o = zero_thr_q;
  assign spacing_o  = spacing_q;

endmodule

>>> rtl/core/ppd_in_stage.sv
// Input register that holds one sample item until the detector takes it.
module ppd_in_stage #(
  parameter int unsigned SAMPLE_WIDTH = ppd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic                           in_last_i,
  output logic                           in_ready_o,
  output logic                           valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  output logic                           last_o,
  input  logic                           advance_i
);
  logic                           valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           last_q;
  logic                           load;

  // The register takes a new item when empty or when its item moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= in_sample_i;
      last_q   <= in_last_i;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;
  assign last_o   = last_q;

endmodule

>>> rtl/core/ppd_detect.sv
// Peak tracking state, open/close decisions and the result register.
module ppd_detect #(
  parameter int unsigned SAMPLE_WIDTH = ppd_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned MAX_ROWS     = ppd_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s1_valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      s1_sample_i,
  input  logic                                s1_last_i,
  output logic                                advance_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      peak_thr_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      zero_thr_i,
  input  logic [ppd_pkg::SPACING_W-1:0]       spacing_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ppd_pkg::ROW_OUT_W-1:0]       baseline_row_o,
  output logic                                flushed_at_end_o
);
  import ppd_pkg::*;

  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned WIDE_W = (ROW_W > SPACING_W) ? ROW_W : SPACING_W;
  localparam int unsigned SE_W   = WIDE_W + 1;
  localparam int unsigned EXT_W  = (ROW_W > ROW_OUT_W) ? ROW_W : ROW_OUT_W;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

  logic                           in_peak_q, in_peak_d;
  logic signed [SAMPLE_WIDTH-1:0] peak_value_q, peak_value_d;
  logic [ROW_W-1:0]               peak_row_q, peak_row_d;
  logic [SE_W-1:0]                search_end_q, search_end_d;
  logic [ROW_W-1:0]               row_q, row_d;

  logic                           out_valid_q;
  logic [ROW_OUT_W-1:0]           row_out_q;
  logic                           flushed_q;

  logic                           emit;
  logic                           emit_flush;
  logic [ROW_W-1:0]               emit_row;
  logic [SE_W-1:0]                row_ext;
  logic [SE_W-1:0]                se_new;
  logic [EXT_W-1:0]               emit_row_ext;

  // An item moves on when the result register is free or being emptied.
  assign advance_o = s1_valid_i && (!out_valid_q || out_ready_i);

  assign row_ext = SE_W'(row_q);
  assign se_new  = row_ext + SE_W'(spacing_i);

  // Open, track and close decisions for the current sample.
  always_comb begin
    in_peak_d    = in_peak_q;
    peak_value_d = peak_value_q;
    peak_row_d   = peak_row_q;
    search_end_d = search_end_q;
    emit         = 1'b0;
    emit_flush   = 1'b0;

    if (!in_peak_q) begin
      if (s1_sample_i > peak_thr_i) begin
        in_peak_d    = 1'b1;
        peak_value_d = s1_sample_i;
        peak_row_d   = row_q;
        search_end_d = se_new;
      end
    end else if (s1_sample_i > peak_value_q) begin
      peak_value_d = s1_sample_i;
      peak_row_d   = row_q;
      search_end_d = se_new;
    end else if ((row_ext > search_end_q) && (s1_sample_i <= zero_thr_i)) begin
      in_peak_d = 1'b0;
      emit      = 1'b1;
    end

    // End of profile: flush a peak that is still open.
    if (s1_last_i) begin
      if (in_peak_d) begin
        in_peak_d  = 1'b0;
        emit       = 1'b1;
        emit_flush = 1'b1;
      end
      row_d = '0;
    end else if (row_q == ROW_LAST) begin
      row_d = '0;
    end else begin
      row_d = row_q + 1'b1;
    end
  end

  assign emit_row     = peak_row_d;
  assign emit_row_ext = EXT_W'(emit_row);

  // Tracking state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_peak_q    <= 1'b0;
      peak_value_q <= '0;
      peak_row_q   <= '0;
      search_end_q <= '0;
      row_q        <= '0;
    end else if (advance_o) begin
      in_peak_q    <= in_peak_d;
      peak_value_q <= peak_value_d;
      peak_row_q   <= peak_row_d;
      search_end_q <= search_end_d;
      row_q        <= row_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (advance_o && emit) begin
      row_out_q <= emit_row_ext[ROW_OUT_W-1:0];
      flushed_q <= emit_flush;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign baseline_row_o   = row_out_q;
  assign flushed_at_end_o = flushed_q;

endmodule

>>> rtl/core/profile_peak_detector.sv
// Top level of the profile peak detector.
//
// Usage: one signed profile sample per row arrives on sample_i, with
// last_sample set on the final row of a profile. A peak opens when a sample
// exceeds the peak threshold and closes once the row is past the search end
// and the sample is at or below the zero threshold; its maximum row then
// leaves on result_o. An open peak is flushed on the last row, marked by
// flushed_at_end. Most items produce no result.
// Configuration: cfg_i writes register 0 (peak threshold), 1 (zero
// threshold) or 2 (minimum spacing); it is always ready and should be used
// only while no item is in flight.
// Timing: an item is taken into the input register, evaluated there, and its
// result is shown from the result register. One item per cycle is accepted
// while result_o does not stall; the single compare-and-update on the input
// register sets that figure.
// Reset clears all tracking state and the row counter, sets the thresholds
// to zero and the spacing to eight. When result_o stalls, the result
// register holds, the input register takes one more item only if it is
// empty, and then sample_i.ready drops until the result is taken.
module profile_peak_detector #(
  parameter int unsigned SAMPLE_WIDTH = ppd_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned MAX_ROWS     = ppd_pkg::MAX_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppd_sample_if.sink sample_i,
  ppd_result_if.source result_o,
  ppd_cfg_if.sink    cfg_i
);
  import ppd_pkg::*;

  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample;
  logic                           s1_last;
  logic                           advance;
  logic signed [SAMPLE_WIDTH-1:0] peak_thr;
  logic signed [SAMPLE_WIDTH-1:0] zero_thr;
  logic [SPACING_W-1:0]           spacing;

  // Configuration registers.
  ppd_cfg_regs #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .peak_thr_o (peak_thr),
    .zero_thr_o (zero_thr),
    .spacing_o  (spacing)
  );

  // Input register.
  ppd_in_stage #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_sample_i (sample_i.sample),
    .in_last_i   (sample_i.last_sample),
    .in_ready_o  (sample_i.ready),
    .valid_o     (s1_valid),
    .sample_o    (s1_sample),
    .last_o      (s1_last),
    .advance_i   (advance)
  );

  // Peak tracking and result register.
  ppd_detect #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_ROWS     (MAX_ROWS)
  ) u_detect (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s1_valid_i       (s1_valid),
    .s1_sample_i      (s1_sample),
    .s1_last_i        (s1_last),
    .advance_o        (advance),
    .peak_thr_i       (peak_thr),
    .zero_thr_i       (zero_thr),
    .spacing_i        (spacing),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .baseline_row_o   (result_o.baseline_row),
    .flushed_at_end_o (result_o.flushed_at_end)
  );

endmodule

>>> rtl/core/ppd_checker.sv
// Port-level checks for the profile peak detector, bound to the top level.
module ppd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ppd_pkg::ROW_OUT_W-1:0] out_row_i,
  input logic                          out_flushed_i
);
  logic in_take;

  assign in_take = in_valid_i && in_ready_i;

  // A pending result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // The result payload holds while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_row_i) && $stable(out_flushed_i))
    else $error("result payload changed while stalled");

  // No result is offered while reset is applied.
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  // A fresh result always comes from an item taken at the input and passed through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_take, 2))
    else $error("result appeared without a matching input item");

endmodule

bind profile_peak_detector ppd_checker u_ppd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (sample_i.valid),
  .in_ready_i    (sample_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_row_i     (result_o.baseline_row),
  .out_flushed_i (result_o.flushed_at_end)
);

>>> bench/profile_peak_detector_tb.sv
// Self-checking testbench for the profile peak detector: directed and random profiles.
module profile_peak_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppd_pkg::*;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int ROW_W        = $clog2(MAX_ROWS_DEF);
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 200;

  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 2'd3;

  // Predicts detected peaks from accepted samples and checks them in order.
  class peak_scoreboard;
    typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic                 flushed;
    } peak_rec_t;

    logic signed [SW-1:0] peak_thr;
    logic signed [SW-1:0] zero_thr;
    logic [SPACING_W-1:0] spacing;
    bit                   open_peak;
    logic signed [SW-1:0] max_val;
    logic [ROW_W-1:0]     max_row;
    logic [ROW_W:0]       end_row;
    logic [ROW_W-1:0]     row_cnt;
    peak_rec_t            peaks_q[$];
    int                   mismatches;

    function void clear();
      peak_thr   = '0;
      zero_thr   = '0;
      spacing    = SPACING_RST;
      open_peak  = 1'b0;
      max_val    = '0;
      max_row    = '0;
      end_row    = '0;
      row_cnt    = '0;
      mismatches = 0;
      peaks_q.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PEAK_THR:    peak_thr = data[SW-1:0];
        REG_ZERO_THR:    zero_thr = data[SW-1:0];
        REG_MIN_SPACING: spacing  = data[SPACING_W-1:0];
        default: ;
      endcase
    endfunction

    // One accepted sample: update the tracking state, queue a peak if one ends.
    function void note_sample(logic signed [SW-1:0] s, logic last);
      bit        emit;
      peak_rec_t rec;
      emit = 1'b0;
      rec  = '0;
      if (!open_peak) begin
        if (s > peak_thr) begin
          open_peak = 1'b1;
          max_val   = s;
          max_row   = row_cnt;
          end_row   = {1'b0, row_cnt} + {1'b0, spacing};
        end
      end else if (s > max_val) begin
        max_val = s;
        max_row = row_cnt;
        end_row = {1'b0, row_cnt} + {1'b0, spacing};
      end else if ({1'b0, row_cnt} > end_row && s <= zero_thr) begin
        open_peak   = 1'b0;
        rec.row     = max_row;
        rec.flushed = 1'b0;
        emit        = 1'b1;
      end
      // The final row flushes a peak that is still open and restarts the rows.
      if (last) begin
        if (open_peak) begin
          open_peak   = 1'b0;
          rec.row     = max_row;
          rec.flushed = 1'b1;
          emit        = 1'b1;
        end
        row_cnt = '0;
      end else begin
        row_cnt = row_cnt + 1'b1;
      end
      if (emit) peaks_q.insert(peaks_q.size(), rec);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(logic [ROW_OUT_W-1:0] row, logic flushed);
      peak_rec_t want;
      if (peaks_q.size() == 0) begin
        report($sformatf("unexpected result row=%0d flushed=%0b", row, flushed));
      end else begin
        want = peaks_q.pop_front();
        if (want.row !== row || want.flushed !== flushed) begin
          report($sformatf("expected row=%0d flushed=%0b, got row=%0d flushed=%0b",
                           want.row, want.flushed, row, flushed));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ppd_sample_if #(.SAMPLE_WIDTH(SW)) smp_if ();
  ppd_result_if                      res_if ();
  ppd_cfg_if                         cfg_if ();

  profile_peak_detector dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(smp_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  peak_scoreboard sb = new();
  bit             idle_on;
  int             hold_asked;
  int             hold_done;
  int             cycle_cnt;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result-side ready: random stall bursts plus long hold-offs on request.
  initial begin : result_ready_drv
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    hold_done    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Result monitor.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready)
        sb.check_result(res_if.baseline_row, res_if.flushed_at_end);
    end
  end

  // Run limit.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** profile_peak_detector: FAILED **");
    $finish;
  end

  // Offer one sample item; starts and ends at a falling edge.
  task automatic send_sample(logic signed [SW-1:0] s, logic last);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      smp_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_if.valid       <= 1'b1;
    smp_if.sample      <= s;
    smp_if.last_sample <= last;
    do @(posedge clk); while (!smp_if.ready);
    sb.note_sample(s, last);
    @(negedge clk);
  endtask

  // Stop offering samples and wait until every expected peak has arrived.
  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    do @(negedge clk); while (sb.peaks_q.size() != 0);
  endtask

  // Register write; valid stays high so that writes can follow back to back.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Program all registers once the block has gone idle.
  task automatic apply_settings(logic signed [SW-1:0] pk, logic signed [SW-1:0] zr,
                                logic [SPACING_W-1:0] sp, bit stray);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write(REG_PEAK_THR, {16'($urandom()), pk});
    cfg_write(REG_ZERO_THR, {16'($urandom()), zr});
    cfg_write(REG_MIN_SPACING, {20'($urandom()), sp});
    if (stray) cfg_write(REG_OUT_OF_RANGE, $urandom());
    cfg_if.valid <= 1'b0;
  endtask

  // Random settings, with the extremes of every register now and then.
  task automatic random_settings();
    int pk;
    int zr;
    int sp;
    case ($urandom_range(0, 9))
      0:       pk = 32767;
      1:       pk = -32768;
      default: pk = int'($urandom_range(0, 6000)) - 2000;
    endcase
    case ($urandom_range(0, 9))
      0:       zr = -32768;
      1:       zr = 32767;
      default: zr = pk - int'($urandom_range(0, 3000));
    endcase
    if (zr < -32768) zr = -32768;
    case ($urandom_range(0, 9))
      0:       sp = 0;
      1:       sp = 4095;
      default: sp = $urandom_range(0, 24);
    endcase
    apply_settings(pk[SW-1:0], zr[SW-1:0], sp[SPACING_W-1:0], $urandom_range(0, 2) == 0);
  endtask

  // Samples shaped around the current thresholds, with full-range noise mixed in.
  function automatic logic signed [SW-1:0] gen_sample();
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      v = int'(sb.peak_thr) + int'($urandom_range(0, 40)) - 10;
    else if (pick < 55) v = int'(sb.zero_thr) - int'($urandom_range(0, 40)) + 5;
    else if (pick < 70) v = int'(sb.peak_thr) + int'($urandom_range(0, 2000));
    else if (pick < 75) v = (pick % 2) ? 32767 : -32768;
    else if (pick < 80) v = int'(sb.max_val);
    else                v = int'($urandom_range(0, 65535)) - 32768;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SW-1:0];
  endfunction

  task automatic send_profile(int len);
    for (int i = 0; i < len; i++) send_sample(gen_sample(), i == len - 1);
  endtask

  // Main stimulus.
  initial begin : stimulus
    int sent;
    int len;
    idle_on            = 1'b1;
    hold_asked         = 0;
    smp_if.valid       = 1'b0;
    smp_if.sample      = '0;
    smp_if.last_sample = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_PEAK_THR;
    cfg_if.data        = '0;
    sb.clear();
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: maximum sample opens, an equal one holds, spacing of eight.
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    repeat (7) send_sample('0, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b1);

    // An equal maximum closes the peak on the last row: one result, not flushed.
    apply_settings(16'sh8000, 16'sh7FFF, '0, 1'b1);
    send_sample(16'sh8001, 1'b0);
    send_sample(16'sh8001, 1'b1);
    send_sample(16'sh8000, 1'b1);

    // Nothing can exceed the top threshold.
    apply_settings(16'sh7FFF, 16'sh8000, 12'd4095, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);

    // A peak that opens on the last row is flushed; then a normal close.
    apply_settings(16'sd100, 16'sd0, 12'd2, 1'b0);
    send_sample(16'sd101, 1'b1);
    send_sample(16'sd50, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd300, 1'b0);
    repeat (3) send_sample(-16'sd5, 1'b0);
    send_sample(16'sd0, 1'b1);

    // Random profiles under changing settings.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      random_settings();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (ph == 2 && sent >= 40 && hold_asked == 0) hold_asked++;
        if (ph == 3 && sent >= 60 && sent < 80) begin
          wait_drained();
          sent = 80;
        end
        // Mostly profiles of 4 to 40 rows, some single rows and some long runs of 60 to 120 rows.
        case ($urandom_range(0, 9))
          0:       len = 1;
          1:       len = $urandom_range(60, 120);
          default: len = $urandom_range(4, 40);
        endcase
        send_profile(len);
        sent += len;
      end
    end

    // Drain and settle, then report.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.peaks_q.size() == 0) begin
      $display("** profile_peak_detector: PASSED **");
    end else begin
      $display("** profile_peak_detector: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ppd_pkg.sv
rtl/core/ppd_if.sv
rtl/core/ppd_cfg_regs.sv
rtl/core/ppd_in_stage.sv
rtl/core/ppd_detect.sv
rtl/core/profile_peak_detector.sv
rtl/core/ppd_checker.sv
bench/profile_peak_detector_tb.sv
